[hdl/vad_pkg.sv]
package vad_pkg;

  // member table size
  localparam int MAX_NODES = 32;

  // member table address and member count widths
  localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  // fixed field widths
  localparam int MODE_W   = 2;
  localparam int VIEW_W   = 32;
  localparam int HASH_W   = 64;
  localparam int ID_W     = 32;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  // request codes, any other code reports like a finalize
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCUM = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOSTART  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

[hdl/vad_ram.sv]
module vad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/vote_accumulator_dedupe_top.sv]
// Vote accumulator with duplicate-node rejection. A start transaction (mode 0)
// opens a fresh accumulator from one commitment: it records view, prepared
// view and the 256-bit prepared hash, stores the node id as the first member
// and sets the count to 1. An accumulate (mode 1) is rejected with status 1
// when its node id is already a member, and with status 2 when the member
// table (vad_pkg::MAX_NODES entries) is full; otherwise the hash and prepared
// view are adopted when the prepared view is strictly higher than the held
// one, and the id is appended. A finalize (mode 2, and also mode 3) changes
// nothing. Accumulate or finalize before any start reports status 3. Every
// input transaction yields exactly one result transaction, which always shows
// the held state after the step. Member ids live in a single-port-read RAM and
// the duplicate check walks it one entry per clock; a duplicate ends the walk
// early at the matching entry. One transaction is processed at a time; a
// waiting result sits in the output register and does not hold off the next
// input once processing completes, but the next result waits until it has
// been taken.
module vote_accumulator_dedupe_top (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] view,
  input  logic [31:0] prep_view,
  input  logic [63:0] prep_hash_0,
  input  logic [63:0] prep_hash_1,
  input  logic [63:0] prep_hash_2,
  input  logic [63:0] prep_hash_3,
  input  logic [31:0] node_id,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] acc_hash_0,
  output logic [63:0] acc_hash_1,
  output logic [63:0] acc_hash_2,
  output logic [63:0] acc_hash_3,
  output logic [31:0] open_view,
  output logic [31:0] top_prep_view,
  output logic [5:0]  count
);

  localparam int AW = vad_pkg::ADDR_W;
  localparam int CW = vad_pkg::CNT_W;

  vad_pkg::state_t  state;
  vad_pkg::status_t rslt;

  // held accumulator state
  logic                          started;
  logic [vad_pkg::HASH_W-1:0]    held_hash [4];
  logic [vad_pkg::VIEW_W-1:0]    held_view;
  logic [vad_pkg::VIEW_W-1:0]    held_just_view;
  logic [CW-1:0]                 member_count;

  // captured accumulate commitment
  logic [vad_pkg::VIEW_W-1:0]    prep_view_q;
  logic [vad_pkg::HASH_W-1:0]    hash_q [4];
  logic [vad_pkg::ID_W-1:0]      id_q;

  // scan pointer and compare slot
  logic [CW-1:0]                 scan_idx;
  logic                          cmp_vld;

  // member table ports
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [vad_pkg::ID_W-1:0]      wr_data;
  logic [vad_pkg::ID_W-1:0]      rd_data;

  logic accept;
  logic issue;
  logic match;
  logic scan_end;
  logic table_full;
  logic append;
  logic out_free;

  // input is taken only in idle, one transaction in flight
  assign in_stall = (state != vad_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // result register frees when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  // scan issues one read per cycle over the live entries, the compare works on the registered read data
  assign match      = cmp_vld && (rd_data == id_q);
  assign issue      = (state == vad_pkg::S_SCAN) && (scan_idx < member_count) && !match;
  assign scan_end   = (state == vad_pkg::S_SCAN) && !issue && !match;
  assign table_full = (member_count >= CW'(vad_pkg::MAX_NODES));
  assign append     = scan_end && !table_full;

  // start writes entry 0, an accepted accumulate appends at the fill count
  always_comb begin
    wr_en   = append || (accept && (mode == vad_pkg::MODE_START));
    wr_addr = '0;
    wr_data = node_id;
    if (state == vad_pkg::S_SCAN) begin
      wr_addr = member_count[AW-1:0];
      wr_data = id_q;
    end
  end

  vad_ram #(
    .WIDTH (vad_pkg::ID_W),
    .DEPTH (vad_pkg::MAX_NODES)
  ) u_ids (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // control and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= vad_pkg::S_IDLE;
      rslt           <= vad_pkg::ST_OK;
      out_valid      <= 1'b0;
      started        <= 1'b0;
      held_hash[0]   <= '0;
      held_hash[1]   <= '0;
      held_hash[2]   <= '0;
      held_hash[3]   <= '0;
      held_view      <= '0;
      held_just_view <= '0;
      member_count   <= '0;
      scan_idx       <= '0;
      cmp_vld        <= 1'b0;
    end else begin
      // a finished step fills the result register, a taken result empties it
      if ((state == vad_pkg::S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      cmp_vld <= issue;
      unique case (state)
        vad_pkg::S_IDLE: begin
          if (accept) begin
            scan_idx <= '0;
            case (mode)
              vad_pkg::MODE_START: begin
                // open a fresh accumulator, any open one is dropped
                started        <= 1'b1;
                held_hash[0]   <= prep_hash_0;
                held_hash[1]   <= prep_hash_1;
                held_hash[2]   <= prep_hash_2;
                held_hash[3]   <= prep_hash_3;
                held_view      <= view;
                held_just_view <= prep_view;
                member_count   <= CW'(1);
                rslt           <= vad_pkg::ST_OK;
                state          <= vad_pkg::S_DONE;
              end
              vad_pkg::MODE_ACCUM: begin
                if (!started) begin
                  rslt  <= vad_pkg::ST_NOSTART;
                  state <= vad_pkg::S_DONE;
                end else begin
                  state <= vad_pkg::S_SCAN;
                end
              end
              default: begin
                // finalize: report only
                rslt  <= started ? vad_pkg::ST_OK : vad_pkg::ST_NOSTART;
                state <= vad_pkg::S_DONE;
              end
            endcase
          end
        end
        vad_pkg::S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (match) begin
            // duplicate wins over the full check
            rslt  <= vad_pkg::ST_DUP;
            state <= vad_pkg::S_DONE;
          end else if (!issue) begin
            if (table_full) begin
              rslt <= vad_pkg::ST_FULL;
            end else begin
              if (prep_view_q > held_just_view) begin
                held_hash[0]   <= hash_q[0];
                held_hash[1]   <= hash_q[1];
                held_hash[2]   <= hash_q[2];
                held_hash[3]   <= hash_q[3];
                held_just_view <= prep_view_q;
              end
              member_count <= member_count + CW'(1);
              rslt         <= vad_pkg::ST_OK;
            end
            state <= vad_pkg::S_DONE;
          end
        end
        vad_pkg::S_DONE: begin
          if (out_free) begin
            state <= vad_pkg::S_IDLE;
          end
        end
        default: begin
          state <= vad_pkg::S_IDLE;
        end
      endcase
    end
  end

  // commitment capture for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      prep_view_q <= prep_view;
      hash_q[0]   <= prep_hash_0;
      hash_q[1]   <= prep_hash_1;
      hash_q[2]   <= prep_hash_2;
      hash_q[3]   <= prep_hash_3;
      id_q        <= node_id;
    end
  end

  // result register, snapshot of the held state after the step
  always_ff @(posedge clk) begin
    if ((state == vad_pkg::S_DONE) && out_free) begin
      status        <= rslt;
      acc_hash_0    <= held_hash[0];
      acc_hash_1    <= held_hash[1];
      acc_hash_2    <= held_hash[2];
      acc_hash_3    <= held_hash[3];
      open_view     <= held_view;
      top_prep_view <= held_just_view;
      count         <= vad_pkg::COUNT_W'(member_count);
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    member_count <= CW'(vad_pkg::MAX_NODES))
    else $error("member count beyond table size");

  // an append never writes past the table
  a_append_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == vad_pkg::S_SCAN)) |-> !table_full)
    else $error("append into a full table");

  // a start leaves exactly one member
  a_start_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == vad_pkg::MODE_START)) |=> (started && (member_count == CW'(1))))
    else $error("start did not open a one-member accumulator");

  // a finished step always lands in the result register
  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    ((state == vad_pkg::S_DONE) && out_free) |=> (out_valid && (state == vad_pkg::S_IDLE)))
    else $error("result not presented after completion");

  // no read is issued outside the scan
  a_scan_only: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == vad_pkg::S_SCAN))
    else $error("compare pending outside scan");
`endif

endmodule
